FILE: src/sorted_table_search_macros.svh
// assertion macros used by the checker file
`ifndef SORTED_TABLE_SEARCH_MACROS_SVH
`define SORTED_TABLE_SEARCH_MACROS_SVH

// same-cycle implication under active-low reset
`define STS_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("sorted_table_search: implication check failed");

// next-cycle implication under active-low reset
`define STS_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("sorted_table_search: next-cycle check failed");

`endif

FILE: src/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// shared widths and codes of the sorted table search block
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 10;
  localparam int unsigned OP_W  = 2;

  // command field codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // operations passed from front to back through the queue
  typedef enum logic [OP_W-1:0] {
    OP_INSERT,
    OP_SEARCH,
    OP_MISS
  } sts_op_e;

endpackage

FILE: src/sts_fifo.sv
// ----------------------------------------------------------------------------
// sts_fifo
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module sts_fifo #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          full_o,
  output logic          empty_o
);

  logic [DW-1:0] mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wr_q <= ~wr_q;
      if (pop_i && !empty_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end

endmodule

FILE: src/sts_front.sv
// ----------------------------------------------------------------------------
// sts_front
// accepts requests, tracks load state and element count, classifies work
// ----------------------------------------------------------------------------
module sts_front #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned CW = $clog2(TABLE_DEPTH + 1),
  parameter int unsigned DW = sts_pkg::OP_W + sts_pkg::VAL_W + CW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic signed [sts_pkg::VAL_W-1:0]  value_i,
  input  logic                              last_i,
  input  logic                              full_i,
  output logic                              push_o,
  output logic [DW-1:0]                     entry_o
);
  import sts_pkg::*;

  logic          load_open_q, load_open_d;
  logic [CW-1:0] count_q, count_d;
  logic          accept;
  sts_op_e       op;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // classify the request
  always_comb begin
    load_open_d = load_open_q;
    count_d     = count_q;
    push_o      = 1'b0;
    op          = OP_MISS;
    if (accept) begin
      if (cmd_i == CMD_LOAD) begin
        if (load_open_q) begin
          if (count_q < CW'(TABLE_DEPTH)) begin
            push_o  = 1'b1;
            op      = OP_INSERT;
            count_d = count_q + CW'(1);
          end
          if (last_i) load_open_d = 1'b0;
        end
      end else begin
        push_o = 1'b1;
        op     = (load_open_q || count_q == '0) ? OP_MISS : OP_SEARCH;
      end
    end
  end

  // insert uses the count as its slot, search as its range
  assign entry_o = {op, value_i, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_open_q <= 1'b1;
      count_q     <= '0;
    end else begin
      load_open_q <= load_open_d;
      count_q     <= count_d;
    end
  end

endmodule

FILE: src/sts_back.sv
// ----------------------------------------------------------------------------
// sts_back
// table memory, insertion on load, binary search on query, result register
// ----------------------------------------------------------------------------
module sts_back #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned CW = $clog2(TABLE_DEPTH + 1),
  parameter int unsigned AW = $clog2(TABLE_DEPTH),
  parameter int unsigned DW = sts_pkg::OP_W + sts_pkg::VAL_W + CW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [DW-1:0]               entry_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [sts_pkg::POS_W-1:0]   position_o
);
  import sts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LINS, S_LCMP, S_SRD, S_SCMP, S_RES
  } state_e;

  state_e                  state_q;
  logic signed [VAL_W-1:0] mem [TABLE_DEPTH];
  logic signed [VAL_W-1:0] rdata_q, key_q;
  logic [AW-1:0]           j_q, m_q;
  logic signed [CW:0]      lo_q, hi_q, m_ext;
  logic signed [CW+1:0]    sum;
  logic [AW-1:0]           mid;
  logic                    hit_q;
  logic                    out_valid_q, found_q;
  logic [POS_W-1:0]        pos_q;

  logic                    we;
  logic [AW-1:0]           wa, ra;
  logic signed [VAL_W-1:0] wd;

  sts_op_e                 e_op;
  logic signed [VAL_W-1:0] e_val;
  logic [CW-1:0]           e_cnt;

  assign e_op  = sts_op_e'(entry_i[DW-1 -: OP_W]);
  assign e_val = entry_i[CW +: VAL_W];
  assign e_cnt = entry_i[CW-1:0];

  assign sum   = (CW+2)'(lo_q) + (CW+2)'(hi_q);
  assign mid   = sum[AW:1];
  assign m_ext = $signed({1'b0, CW'(m_q)});
  assign pop_o = (state_q == S_IDLE) && !empty_i;

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign position_o  = pos_q;

  // memory port selection
  always_comb begin
    we = 1'b0;
    wa = j_q;
    wd = key_q;
    ra = mid;
    case (state_q)
      S_LINS: begin
        ra = j_q - AW'(1);
        if (j_q == '0) we = 1'b1;
      end
      S_LCMP: begin
        we = 1'b1;
        if (rdata_q > key_q) wd = rdata_q;
      end
      default: ;
    endcase
  end

  // table memory with registered read
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rdata_q <= mem[ra];
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      pos_q       <= '0;
      key_q       <= '0;
      j_q         <= '0;
      m_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      hit_q       <= 1'b0;
    end else begin
      if (out_ready_i && state_q != S_RES) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            key_q <= e_val;
            case (e_op)
              OP_INSERT: begin
                j_q     <= e_cnt[AW-1:0];
                state_q <= S_LINS;
              end
              OP_SEARCH: begin
                lo_q    <= '0;
                hi_q    <= $signed({1'b0, e_cnt}) - (CW+1)'(1);
                state_q <= S_SRD;
              end
              default: begin
                hit_q   <= 1'b0;
                state_q <= S_RES;
              end
            endcase
          end
        end
        S_LINS: begin
          if (j_q == '0) state_q <= S_IDLE;
          else state_q <= S_LCMP;
        end
        S_LCMP: begin
          if (rdata_q > key_q) begin
            j_q     <= j_q - AW'(1);
            state_q <= S_LINS;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_SRD: begin
          if (lo_q > hi_q) begin
            hit_q   <= 1'b0;
            state_q <= S_RES;
          end else begin
            m_q     <= mid;
            state_q <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (rdata_q == key_q) begin
            hit_q   <= 1'b1;
            state_q <= S_RES;
          end else begin
            if (rdata_q > key_q) hi_q <= m_ext - (CW+1)'(1);
            else lo_q <= m_ext + (CW+1)'(1);
            state_q <= S_SRD;
          end
        end
        S_RES: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            found_q     <= hit_q;
            pos_q       <= hit_q ? POS_W'(m_q) : '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/sorted_table_search.sv
// ----------------------------------------------------------------------------
// sorted_table_search
// load a table of signed values, keep it sorted, answer lookups by binary search
// ----------------------------------------------------------------------------
// Loads (cmd 0) fill the table and are kept in ascending order by insertion as
// they arrive; last closes the load, later loads are ignored, and loads beyond
// TABLE_DEPTH are dropped. Queries (cmd 1) return found and the sorted position
// (0 on a miss, and always a miss while the load is open). Both kinds of
// request share one single-port-read table memory. In the back, a load shifts
// each larger element up one place until it reaches its slot, and a query
// probes by binary search until a hit or an empty range; a query while the
// load is open or the table is empty goes straight to a miss. A request waits
// in the two-entry queue between the front and the back, which lets requests
// be taken while the back is busy. The table needs no clearing pass after reset.
module sorted_table_search #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             cmd_i,
  input  logic signed [sts_pkg::VAL_W-1:0] value_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             found_o,
  output logic [sts_pkg::POS_W-1:0]        position_o
);
  import sts_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned DW = OP_W + VAL_W + CW;

  logic          push, pop, full, empty;
  logic [DW-1:0] entry_in, entry_out;

  // front: accept and classify
  sts_front #(.TABLE_DEPTH(TABLE_DEPTH), .CW(CW), .DW(DW)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .value_i, .last_i,
    .full_i(full), .push_o(push), .entry_o(entry_in)
  );

  // queue between the two sides
  sts_fifo #(.DW(DW)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(entry_in), .pop_i(pop),
    .data_o(entry_out), .full_o(full), .empty_o(empty)
  );

  // back: memory work and results
  sts_back #(.TABLE_DEPTH(TABLE_DEPTH), .CW(CW), .AW(AW), .DW(DW)) u_back (
    .clk_i, .rst_ni, .entry_i(entry_out), .empty_i(empty), .pop_o(pop),
    .out_valid_o, .out_ready_i, .found_o, .position_o
  );

endmodule

FILE: src/sts_checker.sv
// ----------------------------------------------------------------------------
// sts_checker
// port-level checks of the sorted table search block
// ----------------------------------------------------------------------------
`include "sorted_table_search_macros.svh"

module sts_checker #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      found_o,
  input logic [sts_pkg::POS_W-1:0] position_o
);
  import sts_pkg::*;

  // a stalled result stays up
  `STS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // a stalled result keeps its fields
  `STS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(found_o) && $stable(position_o))

  // a miss reports position zero
  `STS_ASSERT_IMPLY(a_miss_zero, clk_i, rst_ni, out_valid_o && !found_o, position_o == '0)

  // a hit lies inside the table
  `STS_ASSERT_IMPLY(a_hit_range, clk_i, rst_ni, out_valid_o && found_o, (TABLE_DEPTH >= 1024) || (32'(position_o) < TABLE_DEPTH))

endmodule

bind sorted_table_search sts_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_sts_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .found_o, .position_o
);

FILE: tb/sv/tb_sorted_table_search.sv
// ----------------------------------------------------------------------------
// tb_sorted_table_search
// self-checking testbench of the sorted table search block
// ----------------------------------------------------------------------------
// Fills the table up to and past its depth with extreme, duplicate and random
// values, closes the load, then runs lookups of present and absent targets.
// A shadow table predicts every lookup answer, and a scoreboard compares each
// answer with the oldest prediction. Both sides idle at random, and the
// receiver once holds off long enough to back up the block's input.
// ----------------------------------------------------------------------------
module tb_sorted_table_search;
  import sts_pkg::*;

  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned DRAIN_CYC = 3000;
  localparam int unsigned HOLD_CYC  = 600;

  typedef struct packed {
    logic                    cmd;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } table_req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } lookup_ans_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    cmd_i = CMD_LOAD;
  logic signed [VAL_W-1:0] value_i = '0;
  logic                    last_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    found_o;
  logic [POS_W-1:0]        position_o;

  table_req_t  pending_reqs[$];
  lookup_ans_t expected_ans[$];
  int unsigned total_reqs = 0;
  int unsigned sent_cnt = 0;
  int unsigned acc_cnt = 0;
  int unsigned hold_at = 0;
  int unsigned err_cnt = 0;

  // shadow of the block state
  logic signed [VAL_W-1:0] shadow_tbl[DEPTH];
  int unsigned             shadow_cnt = 0;
  bit                      shadow_open = 1'b1;

  sorted_table_search #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .found_o    (found_o),
    .position_o (position_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_cnt++;
  endtask

  task automatic sort_shadow();
    logic signed [VAL_W-1:0] key;
    int unsigned j;
    for (int unsigned i = 1; i < shadow_cnt; i++) begin
      key = shadow_tbl[i];
      j = i;
      while (j > 0 && shadow_tbl[j-1] > key) begin
        shadow_tbl[j] = shadow_tbl[j-1];
        j--;
      end
      shadow_tbl[j] = key;
    end
  endtask

  function automatic lookup_ans_t binary_lookup(input logic signed [VAL_W-1:0] target);
    lookup_ans_t ans;
    longint lo;
    longint hi;
    longint m;
    ans = '0;
    lo = 0;
    hi = longint'(shadow_cnt) - 1;
    while (!ans.found && lo <= hi) begin
      m = (lo + hi) / 2;
      if (shadow_tbl[m] == target) begin
        ans.found = 1'b1;
        ans.position = m[POS_W-1:0];
      end else if (shadow_tbl[m] > target) begin
        hi = m - 1;
      end else begin
        lo = m + 1;
      end
    end
    return ans;
  endfunction

  // predict the effect of one accepted request
  task automatic apply_request(input table_req_t req);
    lookup_ans_t ans;
    if (req.cmd == CMD_LOAD) begin
      if (shadow_open) begin
        if (shadow_cnt < DEPTH) begin
          shadow_tbl[shadow_cnt] = req.value;
          shadow_cnt++;
        end
        if (req.last) begin
          sort_shadow();
          shadow_open = 1'b0;
        end
      end
    end else begin
      ans = '0;
      if (!shadow_open) ans = binary_lookup(req.value);
      expected_ans.push_back(ans);
    end
  endtask

  // request acceptance and answer checking
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      apply_request('{cmd: cmd_i, value: value_i, last: last_i});
      acc_cnt <= acc_cnt + 1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_ans.size() == 0) begin
        report_mismatch("answer with no lookup outstanding");
      end else begin
        if (found_o !== expected_ans[0].found)
          report_mismatch($sformatf("found %b, expected %b", found_o, expected_ans[0].found));
        if (position_o !== expected_ans[0].position)
          report_mismatch($sformatf("position %0d, expected %0d",
                                    position_o, expected_ans[0].position));
        void'(expected_ans.pop_front());
      end
    end
  end

  // driver: bursts of requests with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && acc_cnt != sent_cnt) begin
      // request still waiting for acceptance
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid_i <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      cmd_i <= pending_reqs[0].cmd;
      value_i <= pending_reqs[0].value;
      last_i <= pending_reqs[0].last;
      void'(pending_reqs.pop_front());
      in_valid_i <= 1'b1;
      sent_cnt <= sent_cnt + 1;
      if (burst_left > 1) begin
        burst_left <= burst_left - 1;
      end else begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver: stall pattern plus one long hold-off
  int unsigned stall_mode = 0;
  int unsigned mode_cyc = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (mode_cyc == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_cyc <= $urandom_range(20, 120);
    end else begin
      mode_cyc <= mode_cyc - 1;
    end
    if (!hold_done && hold_at != 0 && acc_cnt >= hold_at) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYC;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic logic signed [VAL_W-1:0] rand_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $signed($urandom_range(0, 16)) - 8;
      1: v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                  : 32'sh8000_0000 + $urandom_range(0, 3);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // stimulus and end of run
  initial begin : stimulus
    logic signed [VAL_W-1:0] loaded[$];
    logic signed [VAL_W-1:0] v;
    int unsigned k;

    // lookups while the load is open, first on an empty table
    pending_reqs.push_back('{CMD_QUERY, 32'sd0, 1'b1});
    pending_reqs.push_back('{CMD_QUERY, 32'sh7FFF_FFFF, 1'b0});
    // extremes and duplicates
    loaded = {32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1, 32'sd5, 32'sd5, 32'sd5,
              32'sh5555_5555, 32'shAAAA_AAAA};
    foreach (loaded[i]) pending_reqs.push_back('{CMD_LOAD, loaded[i], 1'b0});
    // lookup while open with elements present
    pending_reqs.push_back('{CMD_QUERY, 32'sd5, 1'b0});
    // fill the table to its depth
    while (loaded.size() < DEPTH) begin
      v = rand_value();
      loaded.push_back(v);
      pending_reqs.push_back('{CMD_LOAD, v, 1'b0});
      if ($urandom_range(0, 60) == 0)
        pending_reqs.push_back('{CMD_QUERY, v, 1'($urandom_range(0, 1))});
    end
    // load on a full table is dropped but closes the load
    pending_reqs.push_back('{CMD_LOAD, 32'sd12345, 1'b1});
    // loads after close are ignored
    pending_reqs.push_back('{CMD_LOAD, 32'sd777, 1'b1});
    pending_reqs.push_back('{CMD_LOAD, 32'sd778, 1'b0});
    hold_at = pending_reqs.size() + 10;
    // directed lookups
    pending_reqs.push_back('{CMD_QUERY, 32'sh8000_0000, 1'b0});
    pending_reqs.push_back('{CMD_QUERY, 32'sh7FFF_FFFF, 1'b1});
    pending_reqs.push_back('{CMD_QUERY, 32'sd5, 1'b0});
    pending_reqs.push_back('{CMD_QUERY, 32'sd12345, 1'b0});
    pending_reqs.push_back('{CMD_QUERY, 32'sd777, 1'b0});
    // random lookups, half of them of loaded values
    for (int n = 0; n < 500; n++) begin
      k = $urandom_range(0, 3);
      if (k < 2) v = loaded[$urandom_range(0, DEPTH - 1)];
      else if (k == 2) v = loaded[$urandom_range(0, DEPTH - 1)] + ($urandom_range(0, 1) ? 1 : -1);
      else v = rand_value();
      pending_reqs.push_back('{CMD_QUERY, v, 1'($urandom_range(0, 1))});
      if ($urandom_range(0, 50) == 0)
        pending_reqs.push_back('{CMD_LOAD, $urandom, 1'($urandom_range(0, 1))});
    end
    total_reqs = pending_reqs.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (acc_cnt < total_reqs || expected_ans.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_cnt == 0 && expected_ans.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run time limit
  initial begin : watchdog
    #60000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
